>>> src/lskv_pkg.sv
// Package for the log-structured key-value store.
// Holds the request and result payload types, command, status and register codes.
// No dependencies.
`default_nettype none

package lskv_pkg;

	// Default sizing of the log.
	localparam int RUN_DEPTH_DEF   = 64;
	localparam int MAX_RUNS_DEF    = 7;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BYTES_DEF = 8;

	// Configuration register widths and reset values.
	localparam int RUN_SIZE_W  = 7;
	localparam int RUN_LIMIT_W = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam logic [RUN_SIZE_W-1:0]  RUN_SIZE_RST  = 7'd64;
	localparam logic [RUN_LIMIT_W-1:0] RUN_LIMIT_RST = 3'd7;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 1'b1;

	// Command codes. The fourth code is unused and answered with an empty result.
	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_DEL = 2'd1;
	localparam logic [1:0] CMD_GET = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] key;
		logic [63:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [63:0] read_value;
	} out_t;

endpackage

`default_nettype wire

>>> src/log_structured_kv_store.sv
// Top level of the log-structured key-value store: sequencer, log memory, result register.
// Depends on lskv_pkg for payload types and codes.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        request    in_valid/in_ready    in_data   (cmd, key, value)
// out       result     out_valid/out_ready  out_data  (status, found, read_value)
// cfg       write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A put or delete steps through S_WRITE and S_DONE; its result turns valid in the output register
// in the same cycle as the input is ready again. A get steps through S_SCAN, which reads the log
// from the newest entry back, one read per cycle within a run, up to the first matching key (at most
// (MAX_RUNS+1)*RUN_DEPTH entries), stepping back into each sealed run in turn, and then S_DONE.
// The log memory is not cleared at reset; only written entries are ever read.
// A finished result waits in the output register while the next request runs; the
// sequencer holds a new result until the output register is free.
module log_structured_kv_store
	import lskv_pkg::*;
#(
	parameter int RUN_DEPTH   = RUN_DEPTH_DEF,
	parameter int MAX_RUNS    = MAX_RUNS_DEF,
	parameter int KEY_BYTES   = KEY_BYTES_DEF,
	parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  in_t                  in_data,
	output logic                       out_valid,
	input  wire                        out_ready,
	output out_t                       out_data,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [CFG_DATA_W-1:0]      cfg_data
);

	localparam int STORE_DEPTH = (MAX_RUNS + 1) * RUN_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(RUN_DEPTH + 1);
	localparam int RUN_W       = (MAX_RUNS > 0) ? $clog2(MAX_RUNS + 1) : 1;
	localparam int CMP_W       = (FILL_W > RUN_SIZE_W) ? FILL_W : RUN_SIZE_W;
	localparam int LIM_W       = (RUN_W > RUN_LIMIT_W) ? RUN_W : RUN_LIMIT_W;
	localparam int KEY_BITS    = 8 * KEY_BYTES;
	localparam int VALUE_BITS  = 8 * VALUE_BYTES;
	localparam int ENT_W       = KEY_BITS + VALUE_BITS + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WRITE = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [RUN_SIZE_W-1:0]  run_size_q;
	logic [RUN_LIMIT_W-1:0] run_limit_q;

	// Log bookkeeping.
	logic [FILL_W-1:0] fill_q;
	logic [RUN_W-1:0]  sealed_q;
	logic [FILL_W-1:0] run_len_q [MAX_RUNS+1];

	// Latched request.
	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// Scan cursor: run being read and entries of it still to read.
	logic [RUN_W-1:0]  run_q;
	logic [FILL_W-1:0] cnt_q;
	logic              pend_s1;

	// Result waiting for the output register, and the output register itself.
	out_t res_q;
	out_t out_q;
	logic out_valid_q;

	// Log memory: {tombstone, key, value} per entry.
	logic [ENT_W-1:0]  mem [STORE_DEPTH];
	logic [ENT_W-1:0]  rd_s1;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ENT_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	// Effective limits after the saturation rules.
	logic [CMP_W-1:0]  cap;
	logic [LIM_W-1:0]  lim;
	logic              run_full;
	logic              refuse;
	logic              hit;
	logic              out_free;
	logic [RUN_W-1:0]  run_prev;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign run_prev  = RUN_W'(run_q - 1'b1);

	always_comb begin
		cap = CMP_W'(run_size_q);
		if (cap == '0) begin
			cap = CMP_W'(1);
		end
		if (cap > CMP_W'(RUN_DEPTH)) begin
			cap = CMP_W'(RUN_DEPTH);
		end
		lim = LIM_W'(run_limit_q);
		if (lim > LIM_W'(MAX_RUNS)) begin
			lim = LIM_W'(MAX_RUNS);
		end
	end

	assign run_full = CMP_W'(fill_q) >= cap;
	assign refuse   = (LIM_W'(sealed_q) >= lim) || (LIM_W'(sealed_q) >= LIM_W'(MAX_RUNS));

	// A pending read hits when its stored key equals the requested key.
	assign hit = pend_s1 && (rd_s1[VALUE_BITS +: KEY_BITS] == key_q);

	// Memory port control. Writes happen only in S_WRITE and reads only in S_SCAN,
	// so the sequencer itself keeps the two from touching the same entry at once.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(sealed_q) * ADDR_W'(RUN_DEPTH) + ADDR_W'(fill_q);
		mem_wdata = {cmd_q == CMD_DEL, key_q,
			(cmd_q == CMD_DEL) ? {VALUE_BITS{1'b0}} : value_q};
		if (state_q == S_WRITE) begin
			if (!run_full) begin
				mem_we = 1'b1;
			end else if (!refuse) begin
				// Seal the active run and write the first entry of the new one.
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(RUN_W'(sealed_q + 1'b1)) * ADDR_W'(RUN_DEPTH);
			end
		end
		mem_re    = (state_q == S_SCAN) && !hit && (cnt_q != '0);
		mem_raddr = ADDR_W'(run_q) * ADDR_W'(RUN_DEPTH) + ADDR_W'(FILL_W'(cnt_q - 1'b1));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q   <= in_data.cmd;
			key_q   <= in_data.key[KEY_BITS-1:0];
			value_q <= in_data.value[VALUE_BITS-1:0];
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_size_q  <= RUN_SIZE_RST;
			run_limit_q <= RUN_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RUN_SIZE:  run_size_q  <= cfg_data[RUN_SIZE_W-1:0];
				CFG_RUN_LIMIT: run_limit_q <= cfg_data[RUN_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register: loaded from the pending result when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			sealed_q <= '0;
			run_q    <= '0;
			cnt_q    <= '0;
			pend_s1  <= 1'b0;
			res_q    <= '0;
			for (int i = 0; i <= MAX_RUNS; i++) begin
				run_len_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pend_s1 <= 1'b0;
						run_q   <= sealed_q;
						cnt_q   <= fill_q;
						case (in_data.cmd)
							CMD_PUT, CMD_DEL: state_q <= S_WRITE;
							CMD_GET:          state_q <= S_SCAN;
							default: begin
								res_q   <= '{status: ST_OK, found: 1'b0, read_value: '0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WRITE: begin
					if (!run_full) begin
						res_q  <= '{status: ST_OK, found: 1'b0, read_value: '0};
						fill_q <= FILL_W'(fill_q + 1'b1);
					end else if (refuse) begin
						res_q <= '{status: ST_FULL, found: 1'b0, read_value: '0};
					end else begin
						res_q               <= '{status: ST_OK, found: 1'b0, read_value: '0};
						run_len_q[sealed_q] <= fill_q;
						sealed_q            <= RUN_W'(sealed_q + 1'b1);
						fill_q              <= FILL_W'(1);
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (hit) begin
						// The newest matching entry decides; a tombstone reads as a miss.
						if (rd_s1[ENT_W-1]) begin
							res_q <= '{status: ST_MISS, found: 1'b0, read_value: '0};
						end else begin
							res_q <= '{status: ST_OK, found: 1'b1,
								read_value: 64'(rd_s1[VALUE_BITS-1:0])};
						end
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
					end else if (cnt_q != '0) begin
						cnt_q   <= FILL_W'(cnt_q - 1'b1);
						pend_s1 <= 1'b1;
					end else if (run_q != '0) begin
						// Step back into the previous sealed run.
						run_q   <= run_prev;
						cnt_q   <= run_len_q[run_prev];
						pend_s1 <= 1'b0;
					end else begin
						res_q   <= '{status: ST_MISS, found: 1'b0, read_value: '0};
						pend_s1 <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The log memory never sees a write and a read in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("log memory written and read in the same cycle");

	// The bookkeeping counters stay within the log's geometry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= FILL_W'(RUN_DEPTH)) && (LIM_W'(sealed_q) <= LIM_W'(MAX_RUNS)))
		else $error("fill or sealed run count out of range");

	// A live hit always reports status ok.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.found) |-> (out_q.status == ST_OK))
		else $error("found result with a non-ok status");

	// A finished result reaches the output register in the next cycle once it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not delivered to the output register");

endmodule

`default_nettype wire

>>> test/log_structured_kv_store_tb.sv
`timescale 1ns / 1ps
// Testbench for log_structured_kv_store: directed and random put/delete/get traffic,
// checked against a predictor of the log held in this file.
// Depends on lskv_pkg and the log_structured_kv_store RTL.

module log_structured_kv_store_tb;
	import lskv_pkg::*;

	// The unused command code has no name in the package; it must come back as an empty result.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int STORE_SLOTS    = (MAX_RUNS_DEF + 1) * RUN_DEPTH_DEF;
	localparam int KEY_POOL_SIZE  = 8;
	localparam int CHUNK_COUNT    = 12;
	localparam int CHUNK_REQUESTS = 94;
	localparam int HOLD_CYCLES    = 300;
	// A get that misses scans every stored entry before its result appears.
	localparam int DRAIN_CYCLES   = 600;
	localparam int CYCLE_LIMIT    = 3000000;

	localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_3210;
	localparam logic [63:0] KEY_C = 64'h5A5A_0F0F_A5A5_F0F0;
	localparam logic [63:0] KEY_D = 64'h8000_0000_0000_0001;

	// Outcome of scanning one run for a key.
	typedef enum logic [1:0] {
		SCAN_MISS,
		SCAN_LIVE,
		SCAN_TOMBSTONE
	} scan_hit_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	log_structured_kv_store uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted contents of the log. Run r occupies slots r*RUN_DEPTH onward; only slots
	// that were written are ever scanned, just as in the block.
	logic [63:0]     log_key_mem   [STORE_SLOTS];
	logic [63:0]     log_value_mem [STORE_SLOTS];
	logic            log_tomb_mem  [STORE_SLOTS];
	int unsigned     sealed_len    [MAX_RUNS_DEF + 1];
	int unsigned     active_fill  = 0;
	int unsigned     sealed_count = 0;
	logic [6:0]      run_size_reg  = RUN_SIZE_RST;
	logic [2:0]      run_limit_reg = RUN_LIMIT_RST;

	// Results owed by the block, oldest first.
	out_t            pending_results [$];
	logic [63:0]     key_pool [KEY_POOL_SIZE];

	int unsigned     send_idle_pct = 0;
	int unsigned     recv_idle_pct = 0;
	int unsigned     hold_left     = 0;
	int unsigned     error_count   = 0;
	int unsigned     cycle_count   = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void note_failure(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic in_t make_request(input logic [1:0] cmd, input logic [63:0] key,
			input logic [63:0] value);
		in_t req;
		req.cmd = cmd;
		req.key = key;
		req.value = value;
		return req;
	endfunction

	// Effective run capacity: zero acts as one, anything above the run depth saturates.
	function automatic int unsigned run_capacity();
		if (run_size_reg == 0)
			return 1;
		if (run_size_reg > RUN_DEPTH_DEF)
			return RUN_DEPTH_DEF;
		return run_size_reg;
	endfunction

	function automatic int unsigned run_limit_eff();
		return (run_limit_reg > MAX_RUNS_DEF) ? MAX_RUNS_DEF : run_limit_reg;
	endfunction

	// Appends one entry, sealing the active run first when it is full. A seal that would
	// go past the run limit refuses the write and leaves the log untouched.
	function automatic logic [1:0] log_append(input logic [63:0] key, input logic [63:0] value,
			input logic tomb);
		int unsigned slot;
		if (active_fill >= run_capacity()) begin
			if (sealed_count >= run_limit_eff() || sealed_count >= MAX_RUNS_DEF)
				return ST_FULL;
			sealed_len[sealed_count] = active_fill;
			sealed_count++;
			active_fill = 0;
		end
		slot = sealed_count * RUN_DEPTH_DEF + active_fill;
		log_key_mem[slot] = key;
		log_value_mem[slot] = value;
		log_tomb_mem[slot] = tomb;
		active_fill++;
		return ST_OK;
	endfunction

	// Scans one run from its newest entry back; the first key match decides.
	function automatic scan_hit_t scan_run(input int unsigned run_idx, input int unsigned len,
			input logic [63:0] key, output logic [63:0] value);
		int unsigned slot;
		value = '0;
		for (int i = int'(len) - 1; i >= 0; i--) begin
			slot = run_idx * RUN_DEPTH_DEF + i;
			if (log_key_mem[slot] == key) begin
				if (log_tomb_mem[slot])
					return SCAN_TOMBSTONE;
				value = log_value_mem[slot];
				return SCAN_LIVE;
			end
		end
		return SCAN_MISS;
	endfunction

	// Works out the result of one accepted request and updates the predicted log.
	function automatic out_t predict_result(input in_t req);
		out_t        res;
		scan_hit_t   hit;
		logic [63:0] hit_value;
		int unsigned run_idx;
		res = '0;
		res.status = ST_OK;
		case (req.cmd)
		CMD_PUT: res.status = log_append(req.key, req.value, 1'b0);
		CMD_DEL: res.status = log_append(req.key, 64'd0, 1'b1);
		CMD_GET: begin
			// Active run first, then the sealed runs from the latest back.
			hit = scan_run(sealed_count, active_fill, req.key, hit_value);
			run_idx = sealed_count;
			while (hit == SCAN_MISS && run_idx > 0) begin
				run_idx--;
				hit = scan_run(run_idx, sealed_len[run_idx], req.key, hit_value);
			end
			if (hit == SCAN_LIVE) begin
				res.found = 1'b1;
				res.read_value = hit_value;
			end else begin
				res.status = ST_MISS;
			end
		end
		default: res.status = ST_OK;
		endcase
		return res;
	endfunction

	// Offers one request, with random idle cycles ahead of it, and records the
	// expected result once the block accepts it. Returns at the accepting edge.
	task automatic send_request(input in_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(predict_result(req));
	endtask

	// Writes both registers once the block has answered every request. The valid stays
	// high across the two writes so that it is never lowered and raised in one step.
	task automatic write_registers(input logic [CFG_DATA_W-1:0] size_word,
			input logic [CFG_DATA_W-1:0] limit_word);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_RUN_SIZE;
		cfg_data <= size_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		run_size_reg = size_word[6:0];
		cfg_index <= CFG_RUN_LIMIT;
		cfg_data <= limit_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		run_limit_reg = limit_word[2:0];
		cfg_valid <= 1'b0;
	endtask

	// Random traffic is mostly writes and reads over a small pool of keys, so that gets
	// hit live entries, tombstones and older runs; the rest is fresh keys and the unused
	// command.
	function automatic in_t random_request();
		in_t         req;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			req.cmd = CMD_PUT;
		else if (pick < 50)
			req.cmd = CMD_DEL;
		else if (pick < 95)
			req.cmd = CMD_GET;
		else
			req.cmd = CMD_UNUSED;
		req.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
			: random_word();
		req.value = random_word();
		return req;
	endfunction

	// Register settings for the random chunks, {run_size, run_limit}. They run through
	// sizes above the run depth, zero and one, limits below the sealed count and words
	// with the unused upper bits of the limit set. The log fills for good part way through,
	// after which writes are refused and gets scan the whole store.
	function automatic logic [13:0] chunk_setting(input int idx);
		case (idx)
		0:  return {7'd64, 7'd7};
		1:  return {7'd127, 7'h7F};
		2:  return {7'd64, 7'h0B};
		3:  return {7'd64, 7'd1};
		4:  return {7'd48, 7'd7};
		5:  return {7'd64, 7'd0};
		6:  return {7'd64, 7'd7};
		7:  return {7'd1, 7'h7E};
		8:  return {7'd64, 7'd7};
		9:  return {7'd0, 7'd7};
		10: return {7'd20, 7'd3};
		default: return {7'd64, 7'd7};
		endcase
	endfunction

	// Every command on the reset settings, with the extremes of key and value.
	task automatic test_basic_commands();
		send_request(make_request(CMD_PUT, 64'd0, '1));
		send_request(make_request(CMD_PUT, '1, 64'd0));
		send_request(make_request(CMD_GET, 64'd0, 64'd0));
		send_request(make_request(CMD_GET, '1, 64'd0));
		send_request(make_request(CMD_PUT, KEY_A, 64'd1));
		send_request(make_request(CMD_PUT, KEY_A, 64'd2));
		// The newest of two puts to one key must win.
		send_request(make_request(CMD_GET, KEY_A, 64'd0));
		// A delete ignores its value field.
		send_request(make_request(CMD_DEL, KEY_A, random_word()));
		send_request(make_request(CMD_GET, KEY_A, 64'd0));
		send_request(make_request(CMD_GET, KEY_B, 64'd0));
		send_request(make_request(CMD_UNUSED, KEY_A, random_word()));
		// A get ignores its value field too.
		send_request(make_request(CMD_GET, 64'd0, '1));
		send_request(make_request(CMD_PUT, KEY_A, 64'd3));
		send_request(make_request(CMD_GET, KEY_A, 64'd0));
		send_request(make_request(CMD_DEL, '1, 64'd0));
		send_request(make_request(CMD_GET, '1, 64'd0));
	endtask

	// Register corner cases: a run size of zero below the current fill, and a limit that
	// first forbids any seal and then allows exactly two.
	task automatic test_config_corners();
		write_registers(7'd0, 7'd0);
		send_request(make_request(CMD_PUT, KEY_C, random_word()));
		send_request(make_request(CMD_GET, 64'd0, 64'd0));
		write_registers(7'd0, 7'd2);
		send_request(make_request(CMD_PUT, KEY_C, random_word()));
		send_request(make_request(CMD_GET, KEY_A, 64'd0));
		send_request(make_request(CMD_DEL, KEY_C, 64'd0));
		send_request(make_request(CMD_PUT, KEY_D, random_word()));
		send_request(make_request(CMD_GET, KEY_C, 64'd0));
	endtask

	// Four chunks of random requests under one idling pattern, each chunk with its own
	// register setting and up to half the key pool renewed.
	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input int first_chunk);
		logic [13:0] setting;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int c = first_chunk; c < first_chunk + 4; c++) begin
			setting = chunk_setting(c);
			write_registers(setting[13:7], setting[6:0]);
			for (int k = 0; k < KEY_POOL_SIZE / 2; k++)
				key_pool[$urandom_range(KEY_POOL_SIZE - 1)] = random_word();
			for (int n = 0; n < CHUNK_REQUESTS; n++)
				send_request(random_request());
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the block
	// fills its result stages and has to stall its input.
	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		for (int n = 0; n < 16; n++) begin
			if (n % 2 == 0)
				send_request(make_request(CMD_PUT, key_pool[n % KEY_POOL_SIZE], random_word()));
			else
				send_request(make_request(CMD_GET, key_pool[(n - 1) % KEY_POOL_SIZE], 64'd0));
		end
	endtask

	// Result side: check each accepted result against the oldest expectation, then
	// choose the ready for the next cycle. Reading before driving keeps it race free.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result with no request outstanding: status %0d found %0d value %h",
					out_data.status, out_data.found, out_data.read_value));
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status || out_data.found !== want.found
						|| out_data.read_value !== want.read_value)
					note_failure($sformatf({"result mismatch: expected status %0d found %0d value %h,",
						" got status %0d found %0d value %h"}, want.status, want.found,
						want.read_value, out_data.status, out_data.found, out_data.read_value));
			end
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("log_structured_kv_store test failed");
			$finish;
		end
	end

	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_RUN_SIZE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		for (int k = 0; k < KEY_POOL_SIZE; k++)
			key_pool[k] = random_word();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_config_corners();
		test_random_traffic(20, 49, 0);
		test_result_backpressure();
		test_random_traffic(49, 20, 4);
		test_random_traffic(0, 0, 8);

		// Let every owed result arrive, then watch a while longer for stray ones.
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("log_structured_kv_store test passed");
		else
			$display("log_structured_kv_store test failed");
		$finish;
	end

endmodule
